// File: rtl/core/voice_allocator_adsr_envelope_defines.svh
// Assertion macros used by the checker of the voice allocator.
`ifndef VOICE_ALLOCATOR_ADSR_ENVELOPE_DEFINES_SVH
`define VOICE_ALLOCATOR_ADSR_ENVELOPE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define VAAE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define VAAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/vaae_pkg.sv
// Types and constants of the voice allocator with ADSR envelopes.
`timescale 1ns / 1ps

package vaae_pkg;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] LEVEL_TOP = 4'd15;
   localparam logic [7:0] FREE_MARK = 8'h80;

   // Envelope phases
   localparam logic [1:0] PH_ATTACK  = 2'd0;
   localparam logic [1:0] PH_DECAY   = 2'd1;
   localparam logic [1:0] PH_SUSTAIN = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   // Request actions
   localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
   localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
   localparam logic [1:0] ACT_TICK     = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_LEVEL    = 2'd0;
   localparam logic [1:0] KIND_START    = 2'd1;
   localparam logic [1:0] KIND_RELEASED = 2'd2;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_ATTACK  = 3'd0;
   localparam logic [2:0] REG_DECAY   = 3'd1;
   localparam logic [2:0] REG_SUSTAIN = 3'd2;
   localparam logic [2:0] REG_RELEASE = 3'd3;
   localparam logic [2:0] REG_VOICES  = 3'd4;
   localparam logic [2:0] REG_TRACK   = 3'd5;

   typedef struct packed {
      logic [3:0] level;
      logic [1:0] phase;
      logic [3:0] wait_cnt;
      logic       sounding;
   } env_type;

   typedef struct packed {
      logic [3:0] atk;
      logic [3:0] dcy;
      logic [3:0] sus;
      logic [3:0] rel;
   } rates_type;

endpackage

// File: rtl/core/voice_allocator_adsr_envelope.sv
// Top level of the polyphonic voice allocator with per-voice ADSR envelopes.
`timescale 1ns / 1ps

// Polyphonic voice allocator with a 4-bit ADSR envelope on each voice. A request
// word carries an action in req_tuser (note_on, note_off or tick) and note and
// velocity in req_tdata. A small sequencer visits the active voices one per
// cycle, so one word is taken at a time and req_tready stays low until the word
// is done and any last result word is loaded into the output register. With n
// active voices (voices_in_use clamped to 1..MAX_VOICES), note_on runs a
// free/oldest scan, a write, a lowest-note scan (only when track_lowest is set)
// and an emit; note_off runs a scan of the n voices and a lowest-note rescan when
// the released note was the lowest held; tick runs the envelope pass and then
// walks the voice indexes while reporting. The scans go one voice at a time
// through the shared envelope step and age comparator; a stalled result side
// holds the emit. Note_off produces no result words; a tick reports up to eight
// voices whose level changed or that went silent, in voice order, the last one
// flagged by rsp_tlast. A note_on steals the voice with the smallest age stamp
// when no voice is free. Unknown actions are dropped. Registers are to be
// written through the csr_ port only while the block is idle; the block itself
// does not enforce this. There is no clearing pass after reset.
module voice_allocator_adsr_envelope #(
   parameter int MAX_VOICES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [vaae_pkg::REQ_DATA_W-1:0]   req_tdata,  // note[6:0], velocity[13:7], zero[15:14]
   input  logic [vaae_pkg::REQ_USER_W-1:0]   req_tuser,  // action[1:0]
   // Result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [vaae_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // voice[2:0], level[6:3],
                                                         // velocity_out[13:7], silenced[14],
                                                         // stolen[15], lowest_note[22:16],
                                                         // lowest_valid[23]
   output logic [vaae_pkg::RSP_USER_W-1:0]   rsp_tuser,  // kind[1:0]
   output logic                              rsp_tlast,
   // Register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vaae_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vaae_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vaae_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import vaae_pkg::*;

   localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CW = $clog2(MAX_VOICES + 1);

   // Sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_ON_SCAN   = 4'd1;
   localparam logic [3:0] S_ON_WRITE  = 4'd2;
   localparam logic [3:0] S_LOW_SCAN  = 4'd3;
   localparam logic [3:0] S_ON_EMIT   = 4'd4;
   localparam logic [3:0] S_OFF_SCAN  = 4'd5;
   localparam logic [3:0] S_TICK_SCAN = 4'd6;
   localparam logic [3:0] S_TICK_EMIT = 4'd7;
   localparam logic [3:0] S_DROP      = 4'd8;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [3:0] atk_ff, dcy_ff, sus_ff, rel_ff, vin_ff;
   logic       track_ff;
   logic       csr_wr;
   rates_type  rates;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         atk_ff   <= 4'd0;
         dcy_ff   <= 4'd4;
         sus_ff   <= 4'd12;
         rel_ff   <= 4'd4;
         vin_ff   <= 4'd8;
         track_ff <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_ATTACK:  atk_ff   <= csr_pwdata[3:0];
            REG_DECAY:   dcy_ff   <= csr_pwdata[3:0];
            REG_SUSTAIN: sus_ff   <= csr_pwdata[3:0];
            REG_RELEASE: rel_ff   <= csr_pwdata[3:0];
            REG_VOICES:  vin_ff   <= csr_pwdata[3:0];
            REG_TRACK:   track_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ATTACK:  csr_prdata = {28'd0, atk_ff};
         REG_DECAY:   csr_prdata = {28'd0, dcy_ff};
         REG_SUSTAIN: csr_prdata = {28'd0, sus_ff};
         REG_RELEASE: csr_prdata = {28'd0, rel_ff};
         REG_VOICES:  csr_prdata = {28'd0, vin_ff};
         REG_TRACK:   csr_prdata = {31'd0, track_ff};
         default:     csr_prdata = '0;
      endcase
   end

   assign rates = '{atk: atk_ff, dcy: dcy_ff, sus: sus_ff, rel: rel_ff};

   // Clamp the voice count to 1..MAX_VOICES
   logic [CW-1:0] n_act;
   always_comb begin
      if (vin_ff == 4'd0)                n_act = CW'(1);
      else if (int'(vin_ff) > MAX_VOICES) n_act = CW'(MAX_VOICES);
      else                               n_act = CW'(vin_ff);
   end

   // ---------------------------------------------------------------------
   // Voice state
   // ---------------------------------------------------------------------
   logic [7:0]  note_ff [MAX_VOICES];
   logic [6:0]  vel_ff  [MAX_VOICES];
   env_type     env_ff  [MAX_VOICES];
   logic [31:0] age_ff  [MAX_VOICES];
   logic [31:0] age_cnt_ff, age_cnt_in;
   logic [7:0]  lowest_ff, lowest_in;

   // ---------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------
   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [VW-1:0]         best_ff, best_in;
   logic [31:0]           best_age_ff, best_age_in;
   logic                  stole_ff, stole_in;
   logic [7:0]            low_ff, low_in;
   logic [MAX_VOICES-1:0] mask_ff, mask_in;
   logic [2:0]            cnt_ff, cnt_in;
   logic [1:0]            act_ff, act_in;
   logic [6:0]            item_note_ff, item_note_in;
   logic [6:0]            item_vel_ff, item_vel_in;

   // Output register
   logic                  out_vld_ff, out_vld_in;
   logic [1:0]            out_kind_ff, out_kind_in;
   logic [2:0]            out_voice_ff, out_voice_in;
   logic [3:0]            out_level_ff, out_level_in;
   logic [6:0]            out_vel_ff, out_vel_in;
   logic                  out_sil_ff, out_sil_in;
   logic                  out_stl_ff, out_stl_in;
   logic [7:0]            out_low_ff, out_low_in;
   logic                  out_last_ff, out_last_in;

   // Voice read/write port, one address per cycle
   logic [VW-1:0] rd_idx;
   logic [7:0]    note_rd;
   logic [6:0]    vel_rd;
   env_type       env_rd;
   logic [31:0]   age_rd;
   logic          note_we, vel_we, env_we, age_we;
   logic [7:0]    note_in;
   logic [6:0]    vel_in;
   env_type       env_in;
   logic [31:0]   age_in;

   logic [CW-1:0]         idx_plus;
   logic                  last_voice;
   logic                  out_free;
   logic                  req_acc;
   env_type               step_env;
   logic                  step_report;
   logic [MAX_VOICES-1:0] mask_rest;
   logic [7:0]            low_nx;

   assign rd_idx     = (state_ff == S_ON_WRITE || state_ff == S_ON_EMIT) ? best_ff
                                                                         : idx_ff[VW-1:0];
   assign note_rd    = note_ff[rd_idx];
   assign vel_rd     = vel_ff[rd_idx];
   assign env_rd     = env_ff[rd_idx];
   assign age_rd     = age_ff[rd_idx];
   assign idx_plus   = idx_ff + CW'(1);
   assign last_voice = (idx_plus == n_act);
   assign out_free   = !out_vld_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   vaae_env_step u_step (
      .cur    (env_rd),
      .rates  (rates),
      .nxt    (step_env),
      .report (step_report)
   );

   // Lowest held note candidate for the voice under the pointer
   always_comb begin
      low_nx = low_ff;
      if (!note_rd[7] && (low_ff[7] || note_rd < low_ff)) low_nx = note_rd;
   end

   // Mask of reported voices with the current one taken out
   always_comb begin
      mask_rest         = mask_ff;
      mask_rest[rd_idx] = 1'b0;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      best_in      = best_ff;
      best_age_in  = best_age_ff;
      stole_in     = stole_ff;
      low_in       = low_ff;
      mask_in      = mask_ff;
      cnt_in       = cnt_ff;
      act_in       = act_ff;
      item_note_in = item_note_ff;
      item_vel_in  = item_vel_ff;
      age_cnt_in   = age_cnt_ff;
      lowest_in    = lowest_ff;

      note_we = 1'b0;
      vel_we  = 1'b0;
      env_we  = 1'b0;
      age_we  = 1'b0;
      note_in = note_rd;
      vel_in  = item_vel_ff;
      env_in  = env_rd;
      age_in  = age_cnt_ff + 32'd1;

      // Drop the output word once taken
      out_vld_in   = out_vld_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_voice_in = out_voice_ff;
      out_level_in = out_level_ff;
      out_vel_in   = out_vel_ff;
      out_sil_in   = out_sil_ff;
      out_stl_in   = out_stl_ff;
      out_low_in   = out_low_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               act_in       = req_tuser[1:0];
               item_note_in = req_tdata[6:0];
               item_vel_in  = req_tdata[13:7];
               idx_in       = '0;
               mask_in      = '0;
               cnt_in       = 3'd0;
               unique case (req_tuser[1:0])
                  ACT_NOTE_ON:  state_in = S_ON_SCAN;
                  ACT_NOTE_OFF: state_in = S_OFF_SCAN;
                  ACT_TICK:     state_in = S_TICK_SCAN;
                  default:      state_in = S_DROP;
               endcase
            end
         end

         // Take the first free voice, else track the oldest stamp
         S_ON_SCAN: begin
            if (note_rd[7]) begin
               best_in  = rd_idx;
               stole_in = 1'b0;
               state_in = S_ON_WRITE;
            end else begin
               if (idx_ff == '0 || age_rd < best_age_ff) begin
                  best_in     = rd_idx;
                  best_age_in = age_rd;
               end
               if (last_voice) begin
                  stole_in = 1'b1;
                  state_in = S_ON_WRITE;
               end else begin
                  idx_in = idx_plus;
               end
            end
         end

         S_ON_WRITE: begin
            note_we    = 1'b1;
            note_in    = {1'b0, item_note_ff};
            vel_we     = 1'b1;
            vel_in     = item_vel_ff;
            env_we     = 1'b1;
            env_in     = '{level:    (atk_ff == 4'd0) ? sus_ff : 4'd0,
                           phase:    PH_ATTACK,
                           wait_cnt: 4'd0,
                           sounding: 1'b1};
            age_we     = 1'b1;
            age_cnt_in = age_cnt_ff + 32'd1;
            if (track_ff) begin
               idx_in   = '0;
               low_in   = FREE_MARK;
               state_in = S_LOW_SCAN;
            end else begin
               state_in = S_ON_EMIT;
            end
         end

         S_LOW_SCAN: begin
            low_in = low_nx;
            if (last_voice) begin
               lowest_in = low_nx;
               state_in  = (act_ff == ACT_NOTE_ON) ? S_ON_EMIT : S_IDLE;
            end else begin
               idx_in = idx_plus;
            end
         end

         S_ON_EMIT: begin
            if (out_free) begin
               out_vld_in   = 1'b1;
               out_kind_in  = KIND_START;
               out_voice_in = 3'(best_ff);
               out_level_in = env_rd.level;
               out_vel_in   = vel_rd;
               out_sil_in   = stole_ff;
               out_stl_in   = stole_ff;
               out_low_in   = lowest_ff;
               out_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // Free every matching voice and move it to release
         S_OFF_SCAN: begin
            if (note_rd == {1'b0, item_note_ff}) begin
               note_we         = 1'b1;
               note_in         = FREE_MARK;
               env_we          = 1'b1;
               env_in.phase    = PH_RELEASE;
               env_in.wait_cnt = 4'd0;
            end
            if (last_voice) begin
               if (lowest_ff == {1'b0, item_note_ff}) begin
                  idx_in   = '0;
                  low_in   = FREE_MARK;
                  state_in = S_LOW_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               idx_in = idx_plus;
            end
         end

         S_TICK_SCAN: begin
            env_we          = 1'b1;
            env_in          = step_env;
            mask_in[rd_idx] = step_report;
            if (last_voice) begin
               idx_in   = '0;
               state_in = (mask_in != '0) ? S_TICK_EMIT : S_IDLE;
            end else begin
               idx_in = idx_plus;
            end
         end

         // Walk the mask, one reported voice per output word
         S_TICK_EMIT: begin
            if (mask_ff[rd_idx]) begin
               if (out_free) begin
                  out_vld_in   = 1'b1;
                  out_kind_in  = KIND_LEVEL;
                  out_voice_in = 3'(idx_ff);
                  out_level_in = env_rd.level;
                  out_vel_in   = vel_rd;
                  out_sil_in   = !env_rd.sounding;
                  out_stl_in   = 1'b0;
                  out_low_in   = lowest_ff;
                  out_last_in  = (mask_rest == '0) || (cnt_ff == 3'd7);
                  mask_in      = mask_rest;
                  cnt_in       = cnt_ff + 3'd1;
                  if (out_last_in) state_in = S_IDLE;
                  else             idx_in   = idx_plus;
               end
            end else begin
               idx_in = idx_plus;
            end
         end

         S_DROP: state_in = S_IDLE;

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         out_vld_ff <= 1'b0;
         age_cnt_ff <= 32'd0;
         lowest_ff  <= FREE_MARK;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         age_cnt_ff <= age_cnt_in;
         lowest_ff  <= lowest_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_age_ff  <= best_age_in;
      stole_ff     <= stole_in;
      low_ff       <= low_in;
      mask_ff      <= mask_in;
      cnt_ff       <= cnt_in;
      act_ff       <= act_in;
      item_note_ff <= item_note_in;
      item_vel_ff  <= item_vel_in;
      out_kind_ff  <= out_kind_in;
      out_voice_ff <= out_voice_in;
      out_level_ff <= out_level_in;
      out_vel_ff   <= out_vel_in;
      out_sil_ff   <= out_sil_in;
      out_stl_ff   <= out_stl_in;
      out_low_ff   <= out_low_in;
      out_last_ff  <= out_last_in;
   end

   // Voice state: reset clears every entry, then one write port
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            note_ff[i] <= FREE_MARK;
            vel_ff[i]  <= 7'd0;
            env_ff[i]  <= '0;
            age_ff[i]  <= 32'd0;
         end
      end else begin
         if (note_we) note_ff[rd_idx] <= note_in;
         if (vel_we)  vel_ff[rd_idx]  <= vel_in;
         if (env_we)  env_ff[rd_idx]  <= env_in;
         if (age_we)  age_ff[rd_idx]  <= age_in;
      end
   end

   // Result port; lowest_note reads zero when nothing is held
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {!out_low_ff[7],
                        out_low_ff[7] ? 7'd0 : out_low_ff[6:0],
                        out_stl_ff,
                        out_sil_ff,
                        out_vel_ff,
                        out_level_ff,
                        out_voice_ff};

endmodule

// File: rtl/core/vaae_env_step.sv
// One envelope step for one voice: the arithmetic unit shared by all voices.
`timescale 1ns / 1ps

module vaae_env_step (
   input  vaae_pkg::env_type   cur,
   input  vaae_pkg::rates_type rates,
   output vaae_pkg::env_type   nxt,
   output logic                report
);
   import vaae_pkg::*;

   always_comb begin
      nxt    = cur;
      report = 1'b0;
      if (cur.sounding) begin
         if (cur.wait_cnt != 4'd0) begin
            nxt.wait_cnt = cur.wait_cnt - 4'd1;
         end else begin
            unique case (cur.phase)
               PH_ATTACK: begin
                  if (cur.level == LEVEL_TOP || rates.atk == 4'd0) begin
                     nxt.phase = PH_DECAY;
                     if (cur.level < rates.sus) nxt.level = rates.sus;
                  end else begin
                     nxt.level    = cur.level + 4'd1;
                     nxt.wait_cnt = rates.atk - 4'd1;
                  end
                  if (nxt.level == LEVEL_TOP) nxt.phase = PH_DECAY;
               end
               PH_DECAY: begin
                  if (cur.level <= rates.sus || rates.dcy == 4'd0) begin
                     nxt.level = rates.sus;
                     nxt.phase = PH_SUSTAIN;
                  end else begin
                     nxt.level    = cur.level - 4'd1;
                     nxt.wait_cnt = rates.dcy - 4'd1;
                  end
               end
               PH_SUSTAIN: begin
               end
               PH_RELEASE: begin
                  if (cur.level == 4'd0 || rates.rel == 4'd0) begin
                     nxt.level    = 4'd0;
                     nxt.sounding = 1'b0;
                  end else begin
                     nxt.level    = cur.level - 4'd1;
                     nxt.wait_cnt = rates.rel - 4'd1;
                  end
               end
            endcase
            report = (nxt.level != cur.level) || !nxt.sounding;
         end
      end
   end

endmodule

// File: rtl/core/vaae_checker.sv
// Port-level checker for the voice allocator, bound to the top level.
`timescale 1ns / 1ps
`include "voice_allocator_adsr_envelope_defines.svh"

module vaae_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [vaae_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [vaae_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                            rsp_tlast
);
   import vaae_pkg::*;

   // An empty lowest-note slot carries a zero note
   `VAAE_ASSERT_NOW(a_low_zero, clock, reset, rsp_tvalid && !rsp_tdata[23], rsp_tdata[22:16] == 7'd0, "lowest_note set while lowest_valid is low")

   // A steal only shows on a voice-start word that also marks the voice silenced
   `VAAE_ASSERT_NOW(a_steal_start, clock, reset, rsp_tvalid && rsp_tdata[15], rsp_tuser == KIND_START && rsp_tdata[14], "stolen flag outside a started voice")

   // A note_on yields exactly one word
   `VAAE_ASSERT_NOW(a_start_last, clock, reset, rsp_tvalid && rsp_tuser == KIND_START, rsp_tlast, "voice-start word without tlast")

   // One request at a time: busy right after an accept
   `VAAE_ASSERT_NEXT(a_busy_after_acc, clock, reset, req_tvalid && req_tready, !req_tready, "request ready right after an accept")

   // A stalled result word holds
   `VAAE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result word changed")

endmodule

bind voice_allocator_adsr_envelope vaae_checker u_vaae_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
